// ----- design/rmq_pkg.sv -----
`default_nettype none
package rmq_pkg;

    // element format: signed Q2.F
    localparam int ELEM_W   = 16;
    localparam int FRAC     = ELEM_W - 2;
    // numerators are sums or differences of two elements
    localparam int NUM_W    = ELEM_W + 1;
    // radicand = positive 17-bit trace shifted up by F
    localparam int RAD_W    = NUM_W + FRAC;
    localparam int SQ_STEPS = (RAD_W + 1) / 2;
    localparam int ROOT_W   = SQ_STEPS;
    // root is at least 2^(F/2), so quotients stay below 2^QUO_W
    localparam int QUO_W    = RAD_W - FRAC / 2;
    localparam int LANES    = 3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m22;
        logic signed [ELEM_W-1:0] m33;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m21;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] qx;
        logic signed [ELEM_W-1:0] qy;
        logic signed [ELEM_W-1:0] qz;
        logic signed [ELEM_W-1:0] qw;
        logic                     degenerate;
    } t_out;

    // data travelling alongside the root and divide pipelines
    typedef struct packed {
        logic                              deg;
        logic                              wpath;
        logic [1:0]                        axis;
        logic [LANES-1:0]                  neg;
        logic [LANES-1:0][NUM_W-1:0]       mag;
        logic [ELEM_W-1:0]                 dom;
    } t_side;

endpackage
`default_nettype wire

// ----- design/rmq_sqrt.sv -----
`default_nettype none
// pipelined integer square root, one root bit per stage
module rmq_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [rmq_pkg::RAD_W-1:0]    i_rad,
    input  wire rmq_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [rmq_pkg::ROOT_W-1:0]        o_root,
    output rmq_pkg::t_side                    o_side
);
    localparam int N   = rmq_pkg::SQ_STEPS;
    localparam int NW  = 2 * N;
    localparam int RW  = rmq_pkg::ROOT_W;
    localparam int RMW = RW + 3;

    logic                r_v    [N];
    logic [NW-1:0]       r_n    [N];
    logic [RMW-1:0]      r_rem  [N];
    logic [RW-1:0]       r_root [N];
    rmq_pkg::t_side      r_side [N];

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            logic           pv;
            logic [NW-1:0]  pn;
            logic [RMW-1:0] prem;
            logic [RW-1:0]  proot;
            rmq_pkg::t_side pside;
            logic [RMW-1:0] rem_in;
            logic [RMW-1:0] trial;
            logic           ge;

            if (s == 0) begin : g_first
                assign pv    = i_valid;
                assign pn    = NW'(i_rad);
                assign prem  = '0;
                assign proot = '0;
                assign pside = i_side;
            end else begin : g_next
                assign pv    = r_v[s-1];
                assign pn    = r_n[s-1];
                assign prem  = r_rem[s-1];
                assign proot = r_root[s-1];
                assign pside = r_side[s-1];
            end

            assign rem_in = {prem[RMW-3:0], pn[NW-1 -: 2]};
            assign trial  = {1'b0, proot, 2'b01};
            assign ge     = (rem_in >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= pv;
                end
            end

            always_ff @(posedge i_clk) begin
                r_n[s]    <= pn << 2;
                r_rem[s]  <= ge ? (rem_in - trial) : rem_in;
                r_root[s] <= {proot[RW-2:0], ge};
                r_side[s] <= pside;
            end
        end
    endgenerate

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule
`default_nettype wire

// ----- design/rmq_div.sv -----
`default_nettype none
// pipelined restoring divide, three lanes sharing one divisor, one bit per stage
module rmq_div (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_valid,
    input  wire logic [rmq_pkg::LANES-1:0][rmq_pkg::RAD_W-1:0]     i_dvd,
    input  wire logic [rmq_pkg::ROOT_W-1:0]                        i_dvs,
    input  wire rmq_pkg::t_side                                    i_side,
    output logic                                                   o_valid,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]          o_quo,
    output rmq_pkg::t_side                                         o_side
);
    localparam int QW = rmq_pkg::QUO_W;
    localparam int DW = rmq_pkg::RAD_W;
    localparam int RW = rmq_pkg::ROOT_W;
    localparam int PW = RW + 1;
    localparam int L  = rmq_pkg::LANES;

    logic                        r_v    [QW];
    logic [L-1:0][DW-1:0]        r_d    [QW];
    logic [L-1:0][PW-1:0]        r_p    [QW];
    logic [L-1:0][QW-1:0]        r_q    [QW];
    logic [RW-1:0]               r_dvs  [QW];
    rmq_pkg::t_side              r_side [QW];

    genvar s, l;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            localparam int B = QW - 1 - s;
            logic                 pv;
            logic [L-1:0][DW-1:0] pd;
            logic [L-1:0][PW-1:0] pp;
            logic [L-1:0][QW-1:0] pq;
            logic [RW-1:0]        pdvs;
            rmq_pkg::t_side       pside;

            if (s == 0) begin : g_first
                assign pv    = i_valid;
                assign pd    = i_dvd;
                assign pdvs  = i_dvs;
                assign pside = i_side;
                for (l = 0; l < L; l++) begin : g_init
                    assign pp[l] = PW'(i_dvd[l] >> QW);
                    assign pq[l] = '0;
                end
            end else begin : g_next
                assign pv    = r_v[s-1];
                assign pd    = r_d[s-1];
                assign pp    = r_p[s-1];
                assign pq    = r_q[s-1];
                assign pdvs  = r_dvs[s-1];
                assign pside = r_side[s-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= pv;
                end
            end

            for (l = 0; l < L; l++) begin : g_lane
                logic [PW-1:0] pin;
                logic          ge;
                assign pin = {pp[l][PW-2:0], pd[l][B]};
                assign ge  = (pin >= {1'b0, pdvs});
                always_ff @(posedge i_clk) begin
                    r_p[s][l] <= ge ? (pin - {1'b0, pdvs}) : pin;
                    r_q[s][l] <= {pq[l][QW-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                r_d[s]    <= pd;
                r_dvs[s]  <= pdvs;
                r_side[s] <= pside;
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ----- design/rotation_matrix_to_quaternion.sv -----
`default_nettype none
// Rotation matrix to quaternion, Shoemake method, Q2.14 fixed point.
// Input channel: raise start with the ten matrix elements on i_mat; the word
// is taken at the rising edge where start is high and busy is low. busy is
// never raised: the datapath is fully pipelined and takes one word a cycle.
// Output channel: o_strobe is high for one cycle with the quaternion on
// o_quat; there is no back-pressure, the receiver must take it then.
// Path from the accepting edge to the strobe: input register, trace/axis
// select, 16 square-root stages (one root bit each), dividend set-up, 24
// divide stages (one quotient bit each, three lanes sharing the root as
// divisor), output register.
// Throughput: one word per cycle, set by the bit-per-stage root and divide.
// A non-positive radicand yields a zero quaternion with degenerate set.
// Reset (synchronous, active low) clears every stage valid bit, so words in
// flight are dropped and no strobe follows; payload registers are not reset.
module rotation_matrix_to_quaternion (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rmq_pkg::t_in   i_mat,
    output logic                o_strobe,
    output rmq_pkg::t_out       o_quat
);
    localparam int EW = rmq_pkg::ELEM_W;
    localparam int NW = rmq_pkg::NUM_W;
    localparam int FR = rmq_pkg::FRAC;
    localparam int RD = rmq_pkg::RAD_W;
    localparam int RW = rmq_pkg::ROOT_W;
    localparam int QW = rmq_pkg::QUO_W;
    localparam int L  = rmq_pkg::LANES;
    localparam int TW = EW + 3;

    localparam logic signed [TW-1:0] ONE     = TW'(1) << FR;
    localparam logic signed [EW-1:0] EMAX    = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] EMIN    = {1'b1, {(EW-1){1'b0}}};
    localparam logic [QW-1:0]        QMAX    = QW'(EMAX);
    localparam logic [QW-1:0]        QMINMAG = QW'(1) << (EW - 1);

    // pipeline never stalls
    assign busy = 1'b0;

    // input register
    logic          r_v1;
    rmq_pkg::t_in  r_in1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in1 <= i_mat;
    end

    // trace, axis select, radicand and numerators
    logic signed [TW-1:0]        e00, e11, e22, e33, e01, e10, e02, e20, e12, e21;
    logic signed [TW-1:0]        tr4, trb, mii, mjj, mkk;
    logic signed [TW-1:0]        num [L];
    logic                        wpath, deg;
    logic [1:0]                  axis;
    logic [RD-1:0]               n_rad;
    rmq_pkg::t_side              n_side;

    always_comb begin
        e00 = TW'(r_in1.m00);
        e11 = TW'(r_in1.m11);
        e22 = TW'(r_in1.m22);
        e33 = TW'(r_in1.m33);
        e01 = TW'(r_in1.m01);
        e10 = TW'(r_in1.m10);
        e02 = TW'(r_in1.m02);
        e20 = TW'(r_in1.m20);
        e12 = TW'(r_in1.m12);
        e21 = TW'(r_in1.m21);

        tr4   = e00 + e11 + e22 + e33;
        wpath = (tr4 >= ONE);

        // largest diagonal, ties as m00 <= m11 then strict m22
        axis = rmq_pkg::AXIS_X;
        if (e00 <= e11) begin
            axis = rmq_pkg::AXIS_Y;
        end
        if (e22 > ((axis == rmq_pkg::AXIS_Y) ? e11 : e00)) begin
            axis = rmq_pkg::AXIS_Z;
        end

        unique case (axis)
            rmq_pkg::AXIS_Y: begin
                mii = e11; mjj = e22; mkk = e00;
            end
            rmq_pkg::AXIS_Z: begin
                mii = e22; mjj = e00; mkk = e11;
            end
            default: begin
                mii = e00; mjj = e11; mkk = e22;
            end
        endcase
        trb = mii - mjj - mkk + ONE;
        deg = !wpath && (trb <= 0);

        if (wpath) begin
            num[0] = e12 - e21;
            num[1] = e20 - e02;
            num[2] = e01 - e10;
        end else begin
            unique case (axis)
                rmq_pkg::AXIS_Y: begin
                    num[0] = e21 + e12;
                    num[1] = e01 + e10;
                    num[2] = e20 - e02;
                end
                rmq_pkg::AXIS_Z: begin
                    num[0] = e02 + e20;
                    num[1] = e12 + e21;
                    num[2] = e01 - e10;
                end
                default: begin
                    num[0] = e10 + e01;
                    num[1] = e20 + e02;
                    num[2] = e12 - e21;
                end
            endcase
        end

        if (deg) begin
            n_rad = '0;
        end else if (wpath) begin
            n_rad = {tr4[NW-1:0], {FR{1'b0}}};
        end else begin
            n_rad = {trb[NW-1:0], {FR{1'b0}}};
        end

        n_side       = '0;
        n_side.deg   = deg;
        n_side.wpath = wpath;
        n_side.axis  = axis;
        for (int l = 0; l < L; l++) begin
            n_side.neg[l] = num[l][TW-1];
            n_side.mag[l] = num[l][TW-1] ? NW'(-num[l]) : NW'(num[l]);
        end
    end

    logic            r_v2;
    logic [RD-1:0]   r_rad2;
    rmq_pkg::t_side  r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad2  <= n_rad;
        r_side2 <= n_side;
    end

    // square root
    logic            sq_v;
    logic [RW-1:0]   sq_root;
    rmq_pkg::t_side  sq_side;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_rad   (r_rad2),
        .i_side  (r_side2),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // dividends: mag * 2^(F-1) + root/2 for round-to-nearest
    logic                  r_v3;
    logic [L-1:0][RD-1:0]  r_dvd3;
    logic [RW-1:0]         r_dvs3;
    rmq_pkg::t_side        r_side3;
    logic [RW:0]           dom_w;
    rmq_pkg::t_side        n_side3;

    always_comb begin
        dom_w         = ({1'b0, sq_root} + (RW+1)'(1)) >> 1;
        n_side3       = sq_side;
        n_side3.dom   = (dom_w > (RW+1)'(EMAX)) ? EMAX : EW'(dom_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < L; l++) begin
            r_dvd3[l] <= (RD'(sq_side.mag[l]) << (FR - 1)) + RD'(sq_root >> 1);
        end
        r_dvs3  <= sq_root;
        r_side3 <= n_side3;
    end

    // divide
    logic                  dv_v;
    logic [L-1:0][QW-1:0]  dv_quo;
    rmq_pkg::t_side        dv_side;

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_dvd   (r_dvd3),
        .i_dvs   (r_dvs3),
        .i_side  (r_side3),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // sign, saturate, route to components
    function automatic logic signed [EW-1:0] sat_lane(input logic neg,
                                                      input logic [QW-1:0] q);
        logic signed [EW-1:0] res;
        if (!neg) begin
            res = (q > QMAX) ? EMAX : EW'(q);
        end else begin
            res = (q > QMINMAG) ? EMIN : -EW'(q);
        end
        return res;
    endfunction

    logic signed [EW-1:0] lane [L];
    rmq_pkg::t_out        n_quat;

    always_comb begin
        for (int l = 0; l < L; l++) begin
            lane[l] = sat_lane(dv_side.neg[l], dv_quo[l]);
        end
        n_quat = '0;
        if (dv_side.deg) begin
            n_quat.degenerate = 1'b1;
        end else if (dv_side.wpath) begin
            n_quat.qx = lane[0];
            n_quat.qy = lane[1];
            n_quat.qz = lane[2];
            n_quat.qw = dv_side.dom;
        end else begin
            n_quat.qw = lane[2];
            unique case (dv_side.axis)
                rmq_pkg::AXIS_Y: begin
                    n_quat.qy = dv_side.dom;
                    n_quat.qz = lane[0];
                    n_quat.qx = lane[1];
                end
                rmq_pkg::AXIS_Z: begin
                    n_quat.qz = dv_side.dom;
                    n_quat.qx = lane[0];
                    n_quat.qy = lane[1];
                end
                default: begin
                    n_quat.qx = dv_side.dom;
                    n_quat.qy = lane[0];
                    n_quat.qz = lane[1];
                end
            endcase
        end
    end

    logic           r_strobe;
    rmq_pkg::t_out  r_quat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat <= n_quat;
    end

    assign o_strobe = r_strobe;
    assign o_quat   = r_quat;

endmodule
`default_nettype wire
